// ----- hw/rtl/hs_pkg.sv -----
package hs_pkg;

  localparam int DEPTH = 64;
  localparam int VAL_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // One value moving along the cell chain, or held in a cell.
  typedef struct packed {
    logic              valid;
    logic [VAL_W-1:0]  value;
  } hs_link_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SETTLE,
    ST_DRAIN
  } hs_state_t;

endpackage

// ----- hw/rtl/hs_cell.sv -----
module hs_cell
  import hs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     shift,
  input  hs_link_t rip_in,
  input  hs_link_t nbr_in,
  output hs_link_t rip_out,
  output hs_link_t held
);

  logic             slot_valid;
  logic [VAL_W-1:0] slot_value;
  logic             pass_valid;
  logic [VAL_W-1:0] pass_value;
  logic             keep_new;

  assign keep_new = $signed(rip_in.value) < $signed(slot_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      pass_valid <= 1'b0;
    end else if (shift) begin
      slot_valid <= nbr_in.valid;
      pass_valid <= 1'b0;
    end else if (rip_in.valid) begin
      slot_valid <= 1'b1;
      pass_valid <= slot_valid;
    end else begin
      pass_valid <= 1'b0;
    end
  end

  // Keep the smaller value, hand the larger one to the right; on shift, take the right neighbour's value.
  always_ff @(posedge clk) begin
    if (shift) begin
      slot_value <= nbr_in.value;
    end else if (rip_in.valid) begin
      if (!slot_valid || keep_new) begin
        slot_value <= rip_in.value;
      end
      pass_value <= keep_new ? slot_value : rip_in.value;
    end
  end

  assign rip_out.valid = pass_valid;
  assign rip_out.value = pass_value;
  assign held.valid    = slot_valid;
  assign held.value    = slot_value;

endmodule

// ----- hw/rtl/heap_sorter.sv -----
// Channel  Handshake             Payload
// in       in_valid / in_ready   value, last
// out      out_valid / out_ready sorted_value, final_res, overflowed
//
// Values enter a chain of DEPTH insertion cells, one beat per cycle while
// collecting. After the beat flagged last, the chain settles (long enough
// for a value to ripple to the far cell), then drains one result a cycle
// while out_ready is high. Reset empties the chain and clears the count and
// drop flag; input is held off while a set settles or drains, and a stalled
// output freezes the chain.
module heap_sorter
  import hs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VAL_W-1:0] value,
  input  logic             last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] sorted_value,
  output logic             final_res,
  output logic             overflowed
);

  hs_state_t        state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] settle, settle_next;
  logic             dropped, dropped_next;
  logic             take;
  logic             shift;
  hs_link_t         head;
  hs_link_t         rip  [DEPTH];
  hs_link_t         held [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      hs_link_t left_in;
      hs_link_t right_in;
      if (i == 0) begin : g_first
        assign left_in = head;
      end else begin : g_mid
        assign left_in = rip[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
        assign right_in = '0;
      end else begin : g_inner
        assign right_in = held[i+1];
      end
      hs_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (shift),
        .rip_in  (left_in),
        .nbr_in  (right_in),
        .rip_out (rip[i]),
        .held    (held[i])
      );
    end
  endgenerate

  assign sorted_value = held[0].value;
  assign final_res    = !held[1].valid;
  assign overflowed   = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_COLLECT;
      cnt     <= '0;
      settle  <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      settle  <= settle_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    settle_next  = settle;
    dropped_next = dropped;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    take         = 1'b0;
    shift        = 1'b0;
    head.valid   = 1'b0;
    head.value   = value;
    case (state)
      ST_COLLECT: begin
        in_ready = 1'b1;
        take     = in_valid;
        if (take) begin
          if (cnt != DEPTH_C) begin
            head.valid = 1'b1;
            cnt_next   = cnt + 1'b1;
          end else begin
            dropped_next = 1'b1;
          end
          if (last) begin
            settle_next = '0;
            state_next  = ST_SETTLE;
          end
        end
      end
      ST_SETTLE: begin
        settle_next = settle + 1'b1;
        if (settle == DEPTH_C) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        shift     = out_ready;
        // Drop the set after its final beat leaves.
        if (out_ready && final_res) begin
          state_next   = ST_COLLECT;
          cnt_next     = '0;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

endmodule
